>>> src/assert_macros.svh
// assertion macros shared by the lexer modules
// expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

>>> src/ssl_pkg.sv
// shared types, token codes and character helpers for the source lexer
// no dependencies
package ssl_pkg;

   localparam int TOKEN_KIND_W  = 5;
   localparam int TOKEN_VALUE_W = 31;
   localparam int LINE_OUT_W    = 24;
   localparam int CHAR_W        = 8;

   localparam int RSP_DEPTH = 8;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int COUNT_W   = $clog2(RSP_DEPTH + 1);

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [TOKEN_KIND_W-1:0] KIND_IDENT_CHAR  = 5'd0;
   localparam logic [TOKEN_KIND_W-1:0] KIND_STRING_CHAR = 5'd1;
   localparam logic [TOKEN_KIND_W-1:0] KIND_IDENT_END   = 5'd2;
   localparam logic [TOKEN_KIND_W-1:0] KIND_RETURN      = 5'd3;
   localparam logic [TOKEN_KIND_W-1:0] KIND_FN          = 5'd4;
   localparam logic [TOKEN_KIND_W-1:0] KIND_INTEGER     = 5'd5;
   localparam logic [TOKEN_KIND_W-1:0] KIND_STRING_END  = 5'd6;
   localparam logic [TOKEN_KIND_W-1:0] KIND_LPAREN      = 5'd7;
   localparam logic [TOKEN_KIND_W-1:0] KIND_RPAREN      = 5'd8;
   localparam logic [TOKEN_KIND_W-1:0] KIND_LBRACE      = 5'd9;
   localparam logic [TOKEN_KIND_W-1:0] KIND_RBRACE      = 5'd10;
   localparam logic [TOKEN_KIND_W-1:0] KIND_SEMI        = 5'd11;
   localparam logic [TOKEN_KIND_W-1:0] KIND_PLUS        = 5'd12;
   localparam logic [TOKEN_KIND_W-1:0] KIND_MINUS       = 5'd13;
   localparam logic [TOKEN_KIND_W-1:0] KIND_STAR        = 5'd14;
   localparam logic [TOKEN_KIND_W-1:0] KIND_SLASH       = 5'd15;
   localparam logic [TOKEN_KIND_W-1:0] KIND_COMMA       = 5'd16;
   localparam logic [TOKEN_KIND_W-1:0] KIND_ERR_BYTE    = 5'd17;
   localparam logic [TOKEN_KIND_W-1:0] KIND_ERR_STRING  = 5'd18;
   localparam logic [TOKEN_KIND_W-1:0] KIND_END         = 5'd19;

   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_R     = 8'h72;
   localparam logic [CHAR_W-1:0] CHAR_F     = 8'h66;

   typedef struct packed {
      logic [TOKEN_KIND_W-1:0]  kind;
      logic [TOKEN_VALUE_W-1:0] value;
      logic [LINE_OUT_W-1:0]    line;
      logic                     last;
   } token_type;

   // up to two tokens produced by one transaction
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // letters of "return" by position
   function automatic logic [CHAR_W-1:0] kw_return_char(input logic [2:0] idx);
      logic [CHAR_W-1:0] r;
      case (idx)
         3'd0:    r = 8'h72;
         3'd1:    r = 8'h65;
         3'd2:    r = 8'h74;
         3'd3:    r = 8'h75;
         3'd4:    r = 8'h72;
         3'd5:    r = 8'h6E;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // letters of "fn" by position
   function automatic logic [CHAR_W-1:0] kw_fn_char(input logic [2:0] idx);
      logic [CHAR_W-1:0] r;
      case (idx)
         3'd0:    r = 8'h66;
         3'd1:    r = 8'h6E;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // punctuation kind, or the unexpected byte error for anything else
   function automatic logic [TOKEN_KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
      logic [TOKEN_KIND_W-1:0] k;
      case (c)
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h3B:   k = KIND_SEMI;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h2C:   k = KIND_COMMA;
         default: k = KIND_ERR_BYTE;
      endcase
      return k;
   endfunction

endpackage

>>> src/ssl_if.sv
// valid/ready channel interfaces for source bytes and tokens
// depends on ssl_pkg
interface ssl_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [ssl_pkg::CHAR_W-1:0] char_in;

   modport source (output valid, output operation, output char_in, input ready);
   modport sink (input valid, input operation, input char_in, output ready);
endinterface

interface ssl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ssl_pkg::TOKEN_KIND_W-1:0]  token_kind;
   logic [ssl_pkg::TOKEN_VALUE_W-1:0] token_value;
   logic [ssl_pkg::LINE_OUT_W-1:0]    line_number;
   logic                             last_result;

   modport source (output valid, output token_kind, output token_value,
                   output line_number, output last_result, input ready);
   modport sink (input valid, input token_kind, input token_value,
                 input line_number, input last_result, output ready);
endinterface

>>> src/streaming_source_lexer.sv
// top level of the streaming source lexer: input register, scanner, token buffer
// depends on ssl_pkg, ssl_if, ssl_scan, ssl_rsp_fifo and assert_macros.svh
//
//  channel  dir  transaction payload
//  req_if   in   operation, char_in (one source byte or end of code)
//  rsp_if   out  token_kind, token_value, line_number, last_result
//
// one byte per cycle: a transaction is registered, scanned the next cycle and its
// zero to two tokens land in an eight-entry buffer; the buffer read port sets the
// output at one token per cycle
// req_if.ready drops when the buffer cannot take two more tokens for every byte
// in flight, so stalls on rsp_if hold back input without losing anything
// synchronous reset clears the scan state, line count to 1 and empties the buffer
`include "assert_macros.svh"

module streaming_source_lexer #(
   parameter int LINE_BITS = 24,
   parameter int INT_BITS  = 31
) (
   input  logic      clock,
   input  logic      reset,
   ssl_req_if.sink   req_if,
   ssl_rsp_if.source rsp_if
);

   localparam int CW = ssl_pkg::COUNT_W;
   localparam logic [CW:0] ROOM_LIMIT = (CW + 1)'(ssl_pkg::RSP_DEPTH - 2);

   logic                       in_valid_ff, in_valid_in;
   logic                       in_op_ff;
   logic [ssl_pkg::CHAR_W-1:0] in_char_ff;
   logic [CW-1:0]              count;
   logic [CW:0]                reserved;
   logic                       accept;
   ssl_pkg::push_type          push;

   assign reserved     = {1'b0, count} + (in_valid_ff ? (CW + 1)'(2) : (CW + 1)'(0));
   assign req_if.ready = (reserved <= ROOM_LIMIT);
   assign accept       = req_if.valid && req_if.ready;
   assign in_valid_in  = accept;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_if.operation;
         in_char_ff <= req_if.char_in;
      end
   end

   ssl_scan #(
      .LINE_BITS (LINE_BITS),
      .INT_BITS  (INT_BITS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .step  (in_valid_ff),
      .op    (in_op_ff),
      .chr   (in_char_ff),
      .push  (push)
   );

   ssl_rsp_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .rsp_if (rsp_if),
      .count  (count)
   );

   `ASSERT_CLK(a_room_for_byte, in_valid_ff |-> {1'b0, count} <= ROOM_LIMIT + (CW + 1)'(2), "byte in flight without buffer room")

endmodule

>>> src/ssl_scan.sv
// scanner: mode, accumulator, keyword match and line counter, one byte per step
// depends on ssl_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssl_scan #(
   parameter int LINE_BITS = 24,
   parameter int INT_BITS  = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        op,
   input  logic [ssl_pkg::CHAR_W-1:0]  chr,
   output ssl_pkg::push_type           push
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_IDENT  = 3'd1;
   localparam logic [2:0] MODE_NUMBER = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_ERROR  = 3'd4;

   localparam int VW = ssl_pkg::TOKEN_VALUE_W;
   localparam int LW = ssl_pkg::LINE_OUT_W;
   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   logic [2:0]           mode_ff, mode_in;
   logic [INT_BITS-1:0]  accum_ff, accum_in;
   logic                 ovf_ff, ovf_in;
   logic [2:0]           wlen_ff, wlen_in;
   logic                 mret_ff, mret_in;
   logic                 mfn_ff, mfn_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   logic [LW-1:0]                  line_out;
   logic [LINE_BITS+LW-1:0]        line_wide;
   logic [INT_BITS+VW-1:0]         accum_wide;
   logic [VW-1:0]                  char_value;
   logic [3:0]                     digit;
   logic [INT_BITS+3:0]            accum_ext;
   logic [INT_BITS+3:0]            times_ten;

   // idle-mode handling of the current byte, starting from a cleared scan
   logic                           idle_emit;
   logic [ssl_pkg::TOKEN_KIND_W-1:0] idle_kind;
   logic [VW-1:0]                  idle_value;
   logic [2:0]                     idle_mode;
   logic [INT_BITS-1:0]            idle_accum;
   logic [2:0]                     idle_wlen;
   logic                           idle_mret;
   logic                           idle_mfn;
   logic [LINE_BITS-1:0]           idle_line;

   logic                           close_valid;
   logic [ssl_pkg::TOKEN_KIND_W-1:0] close_kind;
   logic [VW-1:0]                  close_value;

   assign line_wide  = {{LW{1'b0}}, line_ff};
   assign line_out   = line_wide[LW-1:0];
   assign char_value = VW'(chr);
   assign digit      = chr[3:0];
   assign accum_ext  = {4'b0000, accum_ff};
   assign times_ten  = (accum_ext << 3) + (accum_ext << 1) + (INT_BITS + 4)'(digit);
   assign accum_wide = {{VW{1'b0}}, (ovf_ff ? {INT_BITS{1'b0}} : accum_ff)};

   always_comb begin
      idle_emit  = 1'b0;
      idle_kind  = ssl_pkg::KIND_ERR_BYTE;
      idle_value = '0;
      idle_mode  = MODE_IDLE;
      idle_accum = '0;
      idle_wlen  = 3'd0;
      idle_mret  = 1'b1;
      idle_mfn   = 1'b1;
      idle_line  = line_ff;
      if (chr == ssl_pkg::CHAR_SPACE || chr == ssl_pkg::CHAR_TAB ||
          chr == ssl_pkg::CHAR_CR) begin
         idle_mode = MODE_IDLE;
      end else if (chr == ssl_pkg::CHAR_LF) begin
         if (line_ff != LINE_MAX) idle_line = line_ff + LINE_ONE;
      end else if (ssl_pkg::is_alpha(chr)) begin
         idle_mode  = MODE_IDENT;
         idle_wlen  = 3'd1;
         idle_mret  = (chr == ssl_pkg::CHAR_R);
         idle_mfn   = (chr == ssl_pkg::CHAR_F);
         idle_emit  = 1'b1;
         idle_kind  = ssl_pkg::KIND_IDENT_CHAR;
         idle_value = char_value;
      end else if (ssl_pkg::is_digit(chr)) begin
         idle_mode  = MODE_NUMBER;
         idle_accum = INT_BITS'(digit);
      end else if (chr == ssl_pkg::CHAR_QUOTE) begin
         idle_mode = MODE_STRING;
      end else begin
         idle_emit = 1'b1;
         idle_kind = ssl_pkg::punct_kind(chr);
         if (idle_kind == ssl_pkg::KIND_ERR_BYTE) idle_mode = MODE_ERROR;
      end
   end

   always_comb begin
      close_valid = (mode_ff == MODE_IDENT) || (mode_ff == MODE_NUMBER);
      close_value = '0;
      if (mode_ff == MODE_NUMBER) begin
         close_kind  = ssl_pkg::KIND_INTEGER;
         close_value = accum_wide[VW-1:0];
      end else if (mret_ff && wlen_ff == 3'd6) begin
         close_kind = ssl_pkg::KIND_RETURN;
      end else if (mfn_ff && wlen_ff == 3'd2) begin
         close_kind = ssl_pkg::KIND_FN;
      end else begin
         close_kind = ssl_pkg::KIND_IDENT_END;
      end
   end

   always_comb begin
      logic use_close;
      logic use_idle;
      use_close = 1'b0;
      use_idle  = 1'b0;
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      ovf_in    = ovf_ff;
      wlen_in   = wlen_ff;
      mret_in   = mret_ff;
      mfn_in    = mfn_ff;
      line_in   = line_ff;
      push      = '0;
      push.first.line  = line_out;
      push.second.line = line_out;

      if (op == ssl_pkg::OP_END) begin
         push.count        = close_valid || mode_ff == MODE_STRING ? 2'd2 : 2'd1;
         push.first.kind   = ssl_pkg::KIND_END;
         push.second.kind  = ssl_pkg::KIND_END;
         if (mode_ff == MODE_STRING) begin
            push.first.kind = ssl_pkg::KIND_ERR_STRING;
         end else if (close_valid) begin
            push.first.kind  = close_kind;
            push.first.value = close_value;
         end
         mode_in  = MODE_IDLE;
         accum_in = '0;
         ovf_in   = 1'b0;
         wlen_in  = 3'd0;
         mret_in  = 1'b1;
         mfn_in   = 1'b1;
         line_in  = LINE_ONE;
      end else begin
         unique case (mode_ff)
            MODE_ERROR: begin
               mode_in = MODE_ERROR;
            end
            MODE_STRING: begin
               push.count = 2'd1;
               if (chr == ssl_pkg::CHAR_QUOTE) begin
                  mode_in         = MODE_IDLE;
                  push.first.kind = ssl_pkg::KIND_STRING_END;
               end else begin
                  push.first.kind  = ssl_pkg::KIND_STRING_CHAR;
                  push.first.value = char_value;
               end
            end
            MODE_IDENT: begin
               if (ssl_pkg::is_alpha(chr) || ssl_pkg::is_digit(chr) ||
                   chr == ssl_pkg::CHAR_UNDER) begin
                  mret_in = mret_ff && wlen_ff < 3'd6 &&
                            ssl_pkg::kw_return_char(wlen_ff) == chr;
                  mfn_in  = mfn_ff && wlen_ff < 3'd2 &&
                            ssl_pkg::kw_fn_char(wlen_ff) == chr;
                  if (wlen_ff != 3'd7) wlen_in = wlen_ff + 3'd1;
                  push.count       = 2'd1;
                  push.first.kind  = ssl_pkg::KIND_IDENT_CHAR;
                  push.first.value = char_value;
               end else begin
                  use_close = 1'b1;
                  use_idle  = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (ssl_pkg::is_digit(chr)) begin
                  if (!ovf_ff) begin
                     if (times_ten[INT_BITS+3:INT_BITS] != 4'd0) ovf_in = 1'b1;
                     else accum_in = times_ten[INT_BITS-1:0];
                  end
               end else begin
                  use_close = 1'b1;
                  use_idle  = 1'b1;
               end
            end
            default: begin
               use_idle = 1'b1;
            end
         endcase

         if (use_idle) begin
            mode_in  = idle_mode;
            accum_in = idle_accum;
            ovf_in   = 1'b0;
            wlen_in  = idle_wlen;
            mret_in  = idle_mret;
            mfn_in   = idle_mfn;
            line_in  = idle_line;
            if (use_close) begin
               push.count        = idle_emit ? 2'd2 : 2'd1;
               push.first.kind   = close_kind;
               push.first.value  = close_value;
               push.second.kind  = idle_kind;
               push.second.value = idle_value;
            end else begin
               push.count       = idle_emit ? 2'd1 : 2'd0;
               push.first.kind  = idle_kind;
               push.first.value = idle_value;
            end
         end
      end

      push.first.last  = (push.count == 2'd1);
      push.second.last = (push.count == 2'd2);
      if (!step) push.count = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         accum_ff <= '0;
         ovf_ff   <= 1'b0;
         wlen_ff  <= 3'd0;
         mret_ff  <= 1'b1;
         mfn_ff   <= 1'b1;
         line_ff  <= LINE_ONE;
      end else if (step) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         ovf_ff   <= ovf_in;
         wlen_ff  <= wlen_in;
         mret_ff  <= mret_in;
         mfn_ff   <= mfn_in;
         line_ff  <= line_in;
      end
   end

   `ASSERT_CLK(a_end_clears, step && op == ssl_pkg::OP_END |=> mode_ff == MODE_IDLE && line_ff == LINE_ONE, "end of code did not restore the scan state")
   `ASSERT_CLK(a_two_tokens_cause, step && push.count == 2'd2 |-> op == ssl_pkg::OP_END || mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER, "two tokens from a byte that closes nothing")
   `ASSERT_NEVER(a_error_silent, step && op == ssl_pkg::OP_BYTE && mode_ff == MODE_ERROR && push.count != 2'd0, "token emitted in error mode")

endmodule

>>> src/ssl_rsp_fifo.sv
// token output buffer: takes up to two tokens per cycle, hands out one
// depends on ssl_pkg, ssl_if and assert_macros.svh
`include "assert_macros.svh"

module ssl_rsp_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  ssl_pkg::push_type            push,
   ssl_rsp_if.source                    rsp_if,
   output logic [ssl_pkg::COUNT_W-1:0]  count
);

   localparam int PW = ssl_pkg::PTR_W;
   localparam int CW = ssl_pkg::COUNT_W;
   localparam logic [CW:0] DEPTH_EXT = (CW + 1)'(ssl_pkg::RSP_DEPTH);

   ssl_pkg::token_type mem [ssl_pkg::RSP_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;
   logic          pop;
   logic [CW:0]   fill_sum;
   ssl_pkg::token_type head;

   assign wr_next   = wr_ptr_ff + PW'(1);
   assign pop       = rsp_if.valid && rsp_if.ready;
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);
   assign fill_sum  = {1'b0, count_ff} + (CW + 1)'(push.count);
   assign count     = count_ff;

   assign head               = mem[rd_ptr_ff];
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.token_kind  = head.kind;
   assign rsp_if.token_value = head.value;
   assign rsp_if.line_number = head.line;
   assign rsp_if.last_result = head.last;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_CLK(a_no_overflow, push.count != 2'd0 |-> fill_sum <= DEPTH_EXT, "token buffer overflow")

endmodule
